// ===== hdl/topq_pkg.sv =====
package topq_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

// ===== hdl/time_ordered_priority_queue_core.sv =====
// pop: reads the head entry, then registers the result; an insert into an empty queue writes it directly
// other inserts walk back from the tail, shifting each entry not earlier than the new one up one place
// full insert or empty pop goes straight to the result; one item at a time, o_stall high while busy
// each step is one registered read and one write of the simple dual-port entry memory
// reset (synchronous, i_rst_n low) empties the queue and drops any pending result
module time_ordered_priority_queue_core import topq_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_command,
    input  logic [TIME_BITS-1:0]         i_event_time,
    input  logic [TAG_BITS-1:0]          i_payload_tag,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [TIME_BITS-1:0]         o_out_time,
    output logic [TAG_BITS-1:0]          o_out_tag,
    output logic                         o_out_valid,
    output logic [1:0]                   o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TIME_BITS + TAG_BITS;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_INS,
        S_NEW,
        S_POP,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_idx;
    logic              r_cmd;
    logic [TIME_BITS-1:0] r_time;
    logic [TAG_BITS-1:0]  r_tag;
    logic [TIME_BITS-1:0] r_p_time;
    logic [TAG_BITS-1:0]  r_p_tag;
    logic              r_p_vld;
    t_status           r_p_st;

    logic              n_we;
    logic [AW-1:0]     n_wlog;
    logic [AW-1:0]     n_waddr;
    logic [AW-1:0]     n_raddr;
    logic [EW-1:0]     n_wdata;
    logic [EW-1:0]     rd_data;
    logic              key_ge;

    // logical position to memory address in the circular store
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] ofs);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, ofs};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    topq_store #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (rd_data)
    );

    // shared compare: stored key against the key being inserted
    assign key_ge = (rd_data[EW-1:TAG_BITS] >= r_time);

    // store access: shift an entry up one place or drop the new entry in
    always_comb begin
        n_we    = (r_state == S_INS) || (r_state == S_NEW);
        n_wlog  = (r_state == S_INS) ? r_idx + AW'(1) : r_idx;
        n_waddr = phys(r_head, n_wlog);
        n_raddr = phys(r_head, r_idx);
        n_wdata = ((r_state == S_INS) && key_ge) ? rd_data : {r_time, r_tag};
    end

    assign o_stall = (r_state != S_IDLE);

    // sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_command;
                        r_time   <= i_event_time;
                        r_tag    <= i_payload_tag;
                        r_p_time <= '0;
                        r_p_tag  <= '0;
                        r_p_vld  <= 1'b0;
                        r_p_st   <= ST_OK;
                        if (i_command == CMD_INSERT) begin
                            if (r_count == DEPTH_C) begin
                                r_p_st  <= ST_FULL;
                                r_state <= S_OUT;
                            end else if (r_count == '0) begin
                                r_idx   <= '0;
                                r_state <= S_NEW;
                            end else begin
                                r_idx   <= AW'(r_count - CW'(1));
                                r_state <= S_RD;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_p_st  <= ST_EMPTY;
                                r_state <= S_OUT;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= (r_cmd == CMD_POP) ? S_POP : S_INS;
                end
                S_INS: begin
                    if (key_ge) begin
                        if (r_idx == '0) begin
                            r_state <= S_NEW;
                        end else begin
                            r_idx   <= r_idx - AW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_NEW: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_OUT;
                end
                S_POP: begin
                    r_p_time <= rd_data[EW-1:TAG_BITS];
                    r_p_tag  <= rd_data[TAG_BITS-1:0];
                    r_p_vld  <= 1'b1;
                    r_head   <= phys(r_head, AW'(1));
                    r_count  <= r_count - CW'(1);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid       <= 1'b1;
                        o_out_time    <= r_p_time;
                        o_out_tag     <= r_p_tag;
                        o_out_valid   <= r_p_vld;
                        o_status      <= r_p_st;
                        o_entry_count <= r_count;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_status == ST_OK)
        else $error("popped entry with error status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_entry_count == DEPTH_C)
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_entry_count == '0 && !o_out_valid)
        else $error("empty status with entries left");

endmodule

// ===== hdl/topq_store.sv =====
module topq_store import topq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== dv/testbench.sv =====
module testbench import topq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int TIME_BITS   = 32;
    localparam int TAG_BITS    = 16;
    localparam int COUNT_BITS  = $clog2(DEPTH + 1);
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [TIME_BITS-1:0] stamp;
        logic [TAG_BITS-1:0]  tag;
    } t_queue_entry;

    typedef struct packed {
        logic [TIME_BITS-1:0]  stamp;
        logic [TAG_BITS-1:0]   tag;
        logic                  hit;
        t_status               status;
        logic [COUNT_BITS-1:0] count;
    } t_queue_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  i_command     = CMD_INSERT;
    logic [TIME_BITS-1:0]  i_event_time  = '0;
    logic [TAG_BITS-1:0]   i_payload_tag = '0;
    logic                  i_stall       = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [TIME_BITS-1:0]  o_out_time;
    logic [TAG_BITS-1:0]   o_out_tag;
    logic                  o_out_valid;
    logic [1:0]            o_status;
    logic [COUNT_BITS-1:0] o_entry_count;

    // predicted contents of the queue, head first, and results still owed
    t_queue_entry  model_entries[$];
    t_queue_result pending_results[$];

    int send_idle_pct  = 13;
    int recv_stall_pct = 13;
    int quiet_cycles   = 0;
    int error_count    = 0;
    int results_seen   = 0;
    int insert_count   = 0;
    int pop_count      = 0;
    int full_drops     = 0;
    int empty_pops     = 0;
    int peak_depth     = 0;

    time_ordered_priority_queue_core #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_event_time  (i_event_time),
        .i_payload_tag (i_payload_tag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_time    (o_out_time),
        .o_out_tag     (o_out_tag),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sorted-insert queue update for one accepted beat
    function automatic void predict_queue_op(logic cmd, logic [TIME_BITS-1:0] stamp,
                                             logic [TAG_BITS-1:0] tag);
        t_queue_result r;
        t_queue_entry  e;
        int            pos;
        r.stamp  = '0;
        r.tag    = '0;
        r.hit    = 1'b0;
        r.status = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (model_entries.size() >= DEPTH) begin
                r.status = ST_FULL;
                full_drops++;
            end else begin
                // first entry not earlier than the new one, so ties go newest first
                pos = model_entries.size();
                for (int i = 0; i < model_entries.size(); i++) begin
                    if (model_entries[i].stamp >= stamp) begin
                        pos = i;
                        break;
                    end
                end
                e.stamp = stamp;
                e.tag   = tag;
                model_entries.insert(pos, e);
                insert_count++;
            end
        end else if (model_entries.size() == 0) begin
            r.status = ST_EMPTY;
            empty_pops++;
        end else begin
            e = model_entries[0];
            model_entries.delete(0);
            r.stamp = e.stamp;
            r.tag   = e.tag;
            r.hit   = 1'b1;
            pop_count++;
        end
        r.count = COUNT_BITS'(model_entries.size());
        if (model_entries.size() > peak_depth) peak_depth = model_entries.size();
        pending_results.push_back(r);
    endfunction

    // timestamps biased toward ties and the ends of the range
    function automatic logic [TIME_BITS-1:0] pick_stamp();
        case ($urandom_range(3))
            0:       return TIME_BITS'($urandom_range(7));
            1:       return '1 - TIME_BITS'($urandom_range(7));
            default: return TIME_BITS'($urandom);
        endcase
    endfunction

    // drive one request beat and wait until it is taken
    task automatic send_item(input logic cmd, input logic [TIME_BITS-1:0] stamp,
                             input logic [TAG_BITS-1:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_event_time  <= stamp;
        i_payload_tag <= tag;
        do @(posedge i_clk); while (o_stall);
        predict_queue_op(cmd, stamp, tag);
    endtask

    task automatic send_random_item(input int insert_pct);
        logic cmd;
        cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_POP;
        send_item(cmd, TIME_BITS'($urandom), TAG_BITS'($urandom));
    endtask

    task automatic send_biased_item(input int insert_pct);
        logic cmd;
        cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_POP;
        send_item(cmd, pick_stamp(), TAG_BITS'($urandom));
    endtask

    // compare one result beat against the oldest prediction
    task automatic check_result();
        t_queue_result want;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            error_count++;
        end else begin
            want = pending_results[0];
            pending_results.delete(0);
            results_seen++;
            if (o_out_time !== want.stamp) begin
                $error("out_time: expected %h, got %h", want.stamp, o_out_time);
                error_count++;
            end
            if (o_out_tag !== want.tag) begin
                $error("out_tag: expected %h, got %h", want.tag, o_out_tag);
                error_count++;
            end
            if (o_out_valid !== want.hit) begin
                $error("out_valid: expected %b, got %b", want.hit, o_out_valid);
                error_count++;
            end
            if (o_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, o_status);
                error_count++;
            end
            if (o_entry_count !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                error_count++;
            end
        end
    endtask

    // result side: check taken beats, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result();
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // cycles in which neither channel moved a beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout after %0d cycles with no beat", QUIET_LIMIT);
        $display("** time_ordered_priority_queue_core: FAILED **");
        $finish;
    end

    // pops right after reset find nothing, whatever the key and tag bits
    task automatic test_empty_pop();
        send_item(CMD_POP, TIME_BITS'($urandom), TAG_BITS'($urandom));
        send_item(CMD_POP, '1, '1);
    endtask

    // extreme keys and equal keys, then pop the two earliest
    task automatic test_ordering();
        send_item(CMD_INSERT, '1, '1);
        send_item(CMD_INSERT, '0, '0);
        send_item(CMD_INSERT, TIME_BITS'(5), TAG_BITS'(16'h1111));
        send_item(CMD_INSERT, TIME_BITS'(5), TAG_BITS'(16'h2222));
        send_item(CMD_POP, '0, '0);
        send_item(CMD_POP, '1, '1);
    endtask

    // fill every slot, then one insert that must be dropped
    task automatic test_full_store();
        while (model_entries.size() < DEPTH)
            send_item(CMD_INSERT, pick_stamp(), TAG_BITS'($urandom));
        send_item(CMD_INSERT, TIME_BITS'($urandom), TAG_BITS'($urandom));
    endtask

    // random traffic, insert share changed every 50 beats to sweep occupancy
    task automatic test_random_mix(input int n_items);
        int mix[5] = '{15, 50, 85, 97, 50};
        int insert_pct;
        insert_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) insert_pct = mix[$urandom_range(4)];
            if ($urandom_range(1)) send_biased_item(insert_pct);
            else send_random_item(insert_pct);
        end
    endtask

    // both sides without any idle or stall
    task automatic test_back_to_back(input int n_items);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < n_items; i++) send_biased_item(i < n_items / 2 ? 80 : 35);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
    endtask

    // sender holds off until every owed result is back
    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++) send_biased_item(70);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 30; i++) send_biased_item(60);
    endtask

    // empty the queue and pop once more
    task automatic test_drain_store();
        while (model_entries.size() != 0) send_item(CMD_POP, pick_stamp(), TAG_BITS'($urandom));
        send_item(CMD_POP, TIME_BITS'($urandom), TAG_BITS'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pop();
        test_ordering();
        test_full_store();
        test_random_mix(950);
        test_back_to_back(200);
        test_drain_pause();
        test_drain_store();

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("ran %0d inserts and %0d pops, %0d inserts on a full queue, %0d pops on empty",
                 insert_count, pop_count, full_drops, empty_pops);
        $display("checked %0d results, peak occupancy %0d of %0d",
                 results_seen, peak_depth, DEPTH);
        if (error_count == 0)
            $display("** time_ordered_priority_queue_core: PASSED **");
        else
            $display("** time_ordered_priority_queue_core: FAILED **");
        $finish;
    end

endmodule
